[rtl/mexp_pkg.sv]
package mexp_pkg;

    // Default operand width
    localparam int DefaultWidth = 16;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    // Start request to the modular multiplier
    typedef struct packed {
        logic start;
    } t_mul_req;

    // Status back from the modular multiplier
    typedef struct packed {
        logic done;
    } t_mul_sts;

endpackage

[rtl/modular_exponentiation_top.sv]
// Modular exponentiation, right-to-left square and multiply.
// Input channel: i_in_valid / o_in_stall with i_base and i_exponent; one beat per
// operation. Output channel: o_out_valid / i_out_stall with o_power_mod, one beat
// per input beat, in order. Configuration: i_cfg_valid / o_cfg_ready with
// i_cfg_data writes the modulus; write it only while no operation is in flight.
// All arithmetic runs through one bit-serial modular multiplier. An operation
// reduces the base, then for every exponent bit squares the running base,
// multiplying it into the accumulator first when the bit is set, and finally
// loads the result into the output register. A modulus below two gives 0
// without using the multiplier. One operation is in flight at a time; the next
// input beat is taken only once the result is loaded into the output register
// and the sequencer is back in idle. Reset sets the modulus to 2 and empties
// the sequencer and output register. While the receiver stalls, the result
// holds; a finished operation waits for the output register to drain before
// returning to idle.
module modular_exponentiation_top #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [WIDTH-1:0] o_power_mod,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [WIDTH-1:0] i_cfg_data
);
    import mexp_pkg::*;

    localparam int BW = $clog2(WIDTH + 1);

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_sq, n_sq;
    logic [WIDTH-1:0] r_res, n_res;
    logic [BW-1:0]    r_bit, n_bit;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;

    t_mul_req         mul_req;
    t_mul_sts         mul_sts;
    logic [WIDTH-1:0] mul_x;
    logic [WIDTH-1:0] mul_y;
    logic [WIDTH-1:0] mul_res;

    logic             in_fire;
    logic             out_free;
    logic             load_out;
    logic [WIDTH-1:0] one_w;

    assign one_w       = {{(WIDTH-1){1'b0}}, 1'b1};
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_fire     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_x      (mul_x),
        .i_y      (mul_y),
        .i_n      (r_modulus),
        .o_sts    (mul_sts),
        .o_result (mul_res)
    );

    // Hold the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(2);
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_data;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    // Sequence: reduce base, then per exponent bit multiply if set, and square
    always_comb begin
        n_state       = r_state;
        n_exp         = r_exp;
        n_acc         = r_acc;
        n_sq          = r_sq;
        n_res         = r_res;
        n_bit         = r_bit;
        mul_req.start = 1'b0;
        mul_x         = r_sq;
        mul_y         = r_sq;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_exp = i_exponent;
                    n_bit = '0;
                    if (r_modulus < WIDTH'(2)) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_x         = one_w;
                        mul_y         = i_base;
                        n_state       = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_sts.done) begin
                    n_sq    = mul_res;
                    n_acc   = one_w;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_bit == BW'(WIDTH)) begin
                    n_res   = r_acc;
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mul_req.start = 1'b1;
                    mul_x         = r_acc;
                    mul_y         = r_sq;
                    n_state       = S_MUL;
                end else begin
                    mul_req.start = 1'b1;
                    n_state       = S_SQR;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    n_acc         = mul_res;
                    mul_req.start = 1'b1;
                    n_state       = S_SQR;
                end
            end
            S_SQR: begin
                if (mul_sts.done) begin
                    n_sq    = mul_res;
                    n_exp   = {1'b0, r_exp[WIDTH-1:1]};
                    n_bit   = r_bit + BW'(1);
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a result, drop it when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_out_data;

endmodule

[rtl/mexp_mulmod.sv]
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mexp_pkg::t_mul_req    i_req,
    input  logic [WIDTH-1:0]      i_x,
    input  logic [WIDTH-1:0]      i_y,
    input  logic [WIDTH-1:0]      i_n,
    output mexp_pkg::t_mul_sts    o_sts,
    output logic [WIDTH-1:0]      o_result
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;
    logic [WIDTH:0]   n_ext;

    // One multiplier bit per cycle, MSB first: acc = 2*acc + ybit*x, mod n
    always_comb begin
        n_ext   = {1'b0, i_n};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum     = dbl_red + (r_y[WIDTH-1] ? {1'b0, r_x} : '0);
        sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
    end

    // Control: count the bits, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift the multiplier out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= sum_red[WIDTH-1:0];
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
        end
    end

    assign o_sts.done = r_done;
    assign o_result   = r_acc;

endmodule

[dv/tb_modular_exponentiation_top.sv]
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

    localparam int W           = mexp_pkg::DefaultWidth;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 600;
    localparam int PHASE_BEATS = 117;
    localparam int NUM_PHASES  = 10;
    localparam int MAX_PRINTS  = 100;

    // One operation in flight: operands, modulus in force, expected power
    typedef struct {
        logic [W-1:0] base;
        logic [W-1:0] exponent;
        logic [W-1:0] modulus;
        logic [W-1:0] power;
    } t_power_beat;

    // Track expected powers in issue order and compare against the output channel
    class t_power_scoreboard;
        logic [W-1:0] modulus;
        t_power_beat  awaited[$];
        int           errors;

        function new();
            modulus = W'(2);
            errors  = 0;
        endfunction

        // Right-to-left square and multiply over every exponent bit
        function logic [W-1:0] predict_power(logic [W-1:0] base, logic [W-1:0] exponent);
            logic [2*W-1:0] n;
            logic [2*W-1:0] acc;
            logic [2*W-1:0] sq;
            n = {{W{1'b0}}, modulus};
            if (n < 2) begin
                return '0;
            end
            acc = 1;
            sq  = base % n;
            for (int k = 0; k < W; k++) begin
                if (exponent[k]) begin
                    acc = (acc * sq) % n;
                end
                sq = (sq * sq) % n;
            end
            return acc[W-1:0];
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function void note_operands(logic [W-1:0] base, logic [W-1:0] exponent);
            t_power_beat beat;
            beat.base     = base;
            beat.exponent = exponent;
            beat.modulus  = modulus;
            beat.power    = predict_power(base, exponent);
            awaited.push_back(beat);
        endfunction

        task check_power(logic [W-1:0] got);
            t_power_beat want;
            if (awaited.size() == 0) begin
                report($sformatf("power 0x%04h arrived with nothing outstanding", got));
                return;
            end
            want = awaited.pop_front();
            if (got !== want.power) begin
                report($sformatf("0x%04h ^ 0x%04h mod 0x%04h: got 0x%04h, want 0x%04h",
                                 want.base, want.exponent, want.modulus, got, want.power));
            end
        endtask

        function int outstanding();
            return awaited.size();
        endfunction

        task flag_leftovers();
            foreach (awaited[i]) begin
                report($sformatf("no result for 0x%04h ^ 0x%04h mod 0x%04h",
                                 awaited[i].base, awaited[i].exponent, awaited[i].modulus));
            end
        endtask
    endclass

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_in_valid  = 1'b0;
    logic         o_in_stall;
    logic [W-1:0] i_base      = '0;
    logic [W-1:0] i_exponent  = '0;
    logic         o_out_valid;
    logic         i_out_stall = 1'b0;
    logic [W-1:0] o_power_mod;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_data  = '0;

    t_power_scoreboard sb = new();

    // Set by the stimulus: no idling on either side while high
    bit calm         = 1'b0;
    // Set by the stimulus, cleared by the receiver once it starts a long hold-off
    bit hold_pending = 1'b0;

    modular_exponentiation_top #(
        .WIDTH(W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_power_mod (o_power_mod),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up after a generous fixed time
    initial begin
        #(30_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_power(o_power_mod);
        end
    end

    // Stall the output at random; on request hold off for a long stretch
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 21);
            end
        end
    end

    // Offer one operand beat, idling first at random, and hold it until taken
    task automatic send_operands(logic [W-1:0] base, logic [W-1:0] exponent);
        while (!calm && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_operands(base, exponent);
    endtask

    // Pick operands with a bias toward the corners
    task automatic send_random_operands();
        logic [W-1:0] base;
        logic [W-1:0] exponent;
        case ($urandom_range(9))
            0:       exponent = '0;
            1:       exponent = W'(1 << $urandom_range(W - 1));
            2:       exponent = '1;
            3, 4:    exponent = W'($urandom_range(255));
            default: exponent = W'($urandom_range(65535));
        endcase
        case ($urandom_range(11))
            0:       base = '0;
            1:       base = W'(1);
            2:       base = '1;
            3:       base = W'(sb.modulus - 1);
            4:       base = sb.modulus;
            default: base = W'($urandom_range(65535));
        endcase
        send_operands(base, exponent);
    endtask

    // Drop valid and wait for every outstanding power to come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the modulus while the block is idle
    task automatic write_modulus(logic [W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.modulus = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [W-1:0] phase_moduli [NUM_PHASES];
        int           waited;

        phase_moduli = '{16'hFFFF, 16'd2, 16'h8000, 16'd65521, 16'd3, 16'd257,
                         16'd0, 16'd0, 16'd0, 16'd0};
        for (int p = 6; p < NUM_PHASES; p++) begin
            phase_moduli[p] = W'($urandom_range(65535, 2));
        end

        // Hold reset, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset modulus of two
        send_operands(16'h0000, 16'h0000);
        send_operands(16'hFFFF, 16'hFFFF);
        send_operands(16'h0001, 16'h0001);
        send_operands(16'h0003, 16'h8000);
        drain_results();

        // Largest modulus: operand extremes, zero exponent, power-of-two exponents
        write_modulus(16'hFFFF);
        send_operands(16'hFFFF, 16'hFFFF);
        send_operands(16'h0000, 16'h0000);
        send_operands(16'h0000, 16'h0005);
        send_operands(16'hFFFE, 16'h0002);
        send_operands(16'd12345, 16'h0001);
        send_operands(16'h0002, 16'h8000);
        send_operands(16'h0007, 16'h0040);
        drain_results();

        // Modulus zero, then one: result is zero even for a zero exponent
        write_modulus(16'd0);
        send_operands(16'h0005, 16'h0007);
        send_operands(16'h0000, 16'h0000);
        drain_results();
        write_modulus(16'd1);
        send_operands(16'h0005, 16'h0007);
        send_operands(16'hFFFF, 16'h0000);
        drain_results();

        // Small textbook key
        write_modulus(16'd3233);
        send_operands(16'd65, 16'd17);
        send_operands(16'd2790, 16'd2753);
        send_operands(16'hFFFF, 16'hFFFF);
        drain_results();

        // Random phases, one modulus each
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_modulus(phase_moduli[p]);
            calm = (p == 4);
            if (p == 2) begin
                hold_pending = 1'b1;
            end
            repeat (PHASE_BEATS) send_random_operands();
            drain_results();
        end
        calm = 1'b0;

        // Wait out the tail, bounded
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
